[hw/rtl/modexp_pkg.sv]
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;

    // Configuration register width and register indexes
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

    localparam logic [CFG_W-1:0] MODULUS_RST  = 32'd2;
    localparam logic [CFG_W-1:0] EXPONENT_RST = 32'd65537;

    // Exponent scan length
    localparam int EXP_BITS  = 32;
    localparam int EXP_CNT_W = 5;

    localparam int MSG_W = 8;
    localparam int OUT_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/modular_exponentiation_encrypt.sv]
// Top level: byte^exponent mod modulus by right-to-left square and multiply.
//
// One request at a time: start is taken while busy is low, and the result is
// shown on cipher_value for one cycle with done high; it cannot be held off.
// All products go through one bit-serial modular multiplier of width W,
// W = min(MOD_BITS, 32). A request costs one reduction of the byte, one square
// per exponent bit (32) and one multiply per set exponent bit. A modulus whose
// low W bits are zero skips the multiplier and answers zero.
module modular_exponentiation_encrypt #(
    parameter int MOD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [modexp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [modexp_pkg::MSG_W-1:0]    message_byte,
    output logic                            done,
    output logic [modexp_pkg::OUT_W-1:0]    cipher_value
);

    localparam int W = (MOD_BITS < 32) ? MOD_BITS : 32;

    modexp_pkg::state_t state_reg, state_next;

    logic [modexp_pkg::CFG_W-1:0]     modulus_reg;
    logic [modexp_pkg::CFG_W-1:0]     exponent_reg;
    logic [modexp_pkg::CFG_W-1:0]     exp_sh_reg;
    logic [modexp_pkg::EXP_CNT_W-1:0] bit_cnt_reg;
    logic [W-1:0]                     acc_reg;
    logic [W-1:0]                     base_reg;

    logic [W-1:0] m_eff;
    logic         m_zero;
    logic         last_bit;
    logic [W-1:0] base_cur;
    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_done;
    logic [W-1:0] mm_p;

    assign m_eff    = modulus_reg[W-1:0];
    assign m_zero   = (m_eff == '0);
    assign last_bit = (bit_cnt_reg == modexp_pkg::EXP_CNT_W'(modexp_pkg::EXP_BITS - 1));

    // Base power as it stands after this edge: a finishing reduce or square hands it over
    assign base_cur = (mm_done && (state_reg inside {modexp_pkg::ST_REDUCE, modexp_pkg::ST_SQR}))
                      ? mm_p : base_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= modexp_pkg::MODULUS_RST;
            exponent_reg <= modexp_pkg::EXPONENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                modexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                modexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = m_zero ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                if (mm_done)
                begin
                    state_next = exp_sh_reg[0] ? modexp_pkg::ST_MUL : modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_MUL:
            begin
                if (mm_done)
                begin
                    state_next = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_SQR:
            begin
                if (mm_done)
                begin
                    if (last_bit)
                    begin
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = exp_sh_reg[1] ? modexp_pkg::ST_MUL : modexp_pkg::ST_SQR;
                    end
                end
            end
            modexp_pkg::ST_DONE:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and multiplier launch; operands follow the state being entered
    always_comb
    begin
        busy     = (state_reg != modexp_pkg::ST_IDLE);
        done     = (state_reg == modexp_pkg::ST_DONE);
        mm_start = 1'b0;
        mm_a     = base_cur;
        mm_b     = base_cur;
        case (state_next)
            modexp_pkg::ST_REDUCE:
            begin
                mm_start = (state_reg == modexp_pkg::ST_IDLE);
                mm_a     = W'(1);
                mm_b     = W'(message_byte);
            end
            modexp_pkg::ST_MUL:
            begin
                mm_start = mm_done;
                mm_b     = acc_reg;
            end
            modexp_pkg::ST_SQR:
            begin
                mm_start = mm_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // 1 mod m: zero for a modulus of one or zero
                    acc_reg     <= (m_eff > W'(1)) ? W'(1) : '0;
                    exp_sh_reg  <= exponent_reg;
                    bit_cnt_reg <= '0;
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                if (mm_done)
                begin
                    base_reg <= mm_p;
                end
            end
            modexp_pkg::ST_MUL:
            begin
                if (mm_done)
                begin
                    acc_reg <= mm_p;
                end
            end
            modexp_pkg::ST_SQR:
            begin
                if (mm_done)
                begin
                    base_reg    <= mm_p;
                    exp_sh_reg  <= {1'b0, exp_sh_reg[modexp_pkg::CFG_W-1:1]};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    modexp_mulmod #(
        .W(W)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (m_eff),
        .done  (mm_done),
        .p     (mm_p)
    );

    assign cipher_value = modexp_pkg::OUT_W'(acc_reg);

endmodule

[hw/rtl/modexp_mulmod.sv]
// Bit-serial interleaved modular multiplier: p = a * b mod m, one bit of b per cycle.
module modexp_mulmod #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] p
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     m_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [W+1:0] t;
    logic [W+1:0] m1;
    logic [W+1:0] m2;

    // One step: double, add a on the current bit of b, reduce (result stays below 3m)
    always_comb
    begin
        m1 = (W+2)'(m_reg);
        m2 = (W+2)'({m_reg, 1'b0});
        t  = (W+2)'({acc_reg, 1'b0}) + (b_reg[W-1] ? (W+2)'(a_reg) : '0);
        if (t >= m2)
        begin
            acc_next = W'(t - m2);
        end
        else if (t >= m1)
        begin
            acc_next = W'(t - m1);
        end
        else
        begin
            acc_next = W'(t);
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
